FILE: src/apr_pkg.sv
// ============================================================================
// apr_pkg - shared types and constants for the aging frame table
// Command codes, item layouts and default sizes used by the interfaces,
// the sweep controller and the top level.
// ============================================================================
package apr_pkg;

    // Default table geometry
    localparam int NUM_FRAMES_DEF = 64;
    localparam int AGE_BITS_DEF   = 32;

    // Fixed field widths of the command and result items
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int PID_W    = 8;
    localparam int START_W  = 32;
    localparam int VICTIM_W = 6;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ACCESS = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_EVICT  = 2'd3
    } t_command;

    // Result status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // One command item
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SLOT_W-1:0]  frame_slot;
        logic [PID_W-1:0]   process_id;
        logic [START_W-1:0] start_age;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic                status;
        logic [VICTIM_W-1:0] victim_frame;
    } t_res;

endpackage

FILE: src/apr_if.sv
// ============================================================================
// apr_if - valid/ready channels of the aging frame table
// Command channel carries one operation per item; result channel carries
// the status and victim frame of that operation.
// ============================================================================
interface apr_cmd_if import apr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  frame_slot;
    logic [PID_W-1:0]   process_id;
    logic [START_W-1:0] start_age;

    modport source (output valid, command, frame_slot, process_id, start_age,
                    input ready);
    modport sink   (input valid, command, frame_slot, process_id, start_age,
                    output ready);
endinterface

interface apr_res_if import apr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                status;
    logic [VICTIM_W-1:0] victim_frame;

    modport source (output valid, status, victim_frame, input ready);
    modport sink   (input valid, status, victim_frame, output ready);
endinterface

FILE: src/apr_frame_ram.sv
// ============================================================================
// apr_frame_ram - frame table storage
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read (read-before-write on a collision).
// ============================================================================
module apr_frame_ram import apr_pkg::*; #(
    parameter int DEPTH = NUM_FRAMES_DEF,
    parameter int WIDTH = AGE_BITS_DEF + 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/apr_sweep_ctrl.sv
// ============================================================================
// apr_sweep_ctrl - command sequencer of the aging frame table
// Runs the clearing pass after reset, then executes one command at a time:
// direct write for insert, read-modify-write for access, a pipelined sweep
// over all slots with write-back for aging tick and without it for evict.
// ============================================================================
module apr_sweep_ctrl import apr_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int AGE_BITS   = AGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command side
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  t_cmd                          i_cmd,
    // result side
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output t_res                          o_res,
    // table RAM
    output logic                          o_mem_we,
    output logic [$clog2(NUM_FRAMES)-1:0] o_mem_waddr,
    output logic [AGE_BITS+9:0]           o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(NUM_FRAMES)-1:0] o_mem_raddr,
    input  logic [AGE_BITS+9:0]           i_mem_rdata
);

    localparam int IDX_W   = $clog2(NUM_FRAMES);
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
    localparam int WORD_W  = AGE_BITS + 10;
    // Word layout: {valid, referenced, owner, age}
    localparam int OWN_LSB = AGE_BITS;
    localparam int REF_BIT = AGE_BITS + PID_W;
    localparam int VAL_BIT = AGE_BITS + PID_W + 1;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_INSERT   = 7'b0000100,
        S_ACC_RD   = 7'b0001000,
        S_ACC_WR   = 7'b0010000,
        S_SWEEP    = 7'b0100000,
        S_EVICT_WR = 7'b1000000
    } t_state;

    // S_DONE is folded into the result hand-off flag below
    t_state              r_state, n_state;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_rd_v, n_rd_v;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    t_cmd                r_item, n_item;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [AGE_BITS-1:0] r_best_age, n_best_age;
    t_res                r_res, n_res;

    logic [IDX_W-1:0]    slot_idx;
    logic                in_slot_ok;
    logic                rd_valid;
    logic                rd_ref;
    logic [PID_W-1:0]    rd_owner;
    logic [AGE_BITS-1:0] rd_age;

    // Decode the item and the word read back
    assign slot_idx   = IDX_W'(r_item.frame_slot);
    assign in_slot_ok = 32'(i_cmd.frame_slot) < 32'(NUM_FRAMES);
    assign rd_valid   = i_mem_rdata[VAL_BIT];
    assign rd_ref     = i_mem_rdata[REF_BIT];
    assign rd_owner   = i_mem_rdata[REF_BIT-1:OWN_LSB];
    assign rd_age     = i_mem_rdata[AGE_BITS-1:0];

    assign o_cmd_ready = (r_state == S_IDLE) && !r_done;
    assign o_res_valid = r_done;
    assign o_res       = r_res;

    // Sequence the commands
    always_comb begin
        n_state     = r_state;
        n_done      = r_done;
        n_idx       = r_idx;
        n_rd_v      = 1'b0;
        n_rd_idx    = r_idx[IDX_W-1:0];
        n_item      = r_item;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_age  = r_best_age;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = slot_idx;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[IDX_W-1:0];

        case (r_state)
            S_CLEAR: begin
                // free every slot, one a cycle
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx[IDX_W-1:0];
                n_idx       = r_idx + 1'b1;
                if (r_idx == CNT_W'(NUM_FRAMES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_done) begin
                    if (i_res_ready) begin
                        n_done = 1'b0;
                    end
                end else if (i_cmd_valid) begin
                    n_item  = i_cmd;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_res   = '{status: STATUS_DONE, victim_frame: '0};
                    case (t_command'(i_cmd.command))
                        CMD_INSERT: begin
                            if (in_slot_ok) begin
                                n_state = S_INSERT;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        CMD_ACCESS: begin
                            if (in_slot_ok) begin
                                n_state = S_ACC_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_SWEEP;
                        end
                    endcase
                end
            end
            S_INSERT: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = {1'b1, 1'b0, r_item.process_id,
                               AGE_BITS'(r_item.start_age)};
                n_state     = S_IDLE;
                n_done      = 1'b1;
            end
            S_ACC_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = slot_idx;
                n_state     = S_ACC_WR;
            end
            S_ACC_WR: begin
                // mark only a resident frame
                if (rd_valid) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata | (WORD_W'(1) << REF_BIT);
                end
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_SWEEP: begin
                // issue the next read while the previous word is processed
                if (r_idx != CNT_W'(NUM_FRAMES)) begin
                    o_mem_re = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_rd_v   = 1'b1;
                end else if (r_item.command == CMD_EVICT) begin
                    n_state = S_EVICT_WR;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
                if (r_rd_v) begin
                    if (r_item.command == CMD_EVICT) begin
                        if (rd_valid && (!r_found || rd_age < r_best_age)) begin
                            n_found    = 1'b1;
                            n_best_idx = r_rd_idx;
                            n_best_age = rd_age;
                        end
                    end else if (rd_valid && rd_owner == r_item.process_id) begin
                        // age: shift right, mark into the top bit, clear mark
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_rd_idx;
                        o_mem_wdata = {1'b1, 1'b0, rd_owner,
                                       rd_ref, rd_age[AGE_BITS-1:1]};
                    end
                end
            end
            S_EVICT_WR: begin
                if (r_found) begin
                    o_mem_we           = 1'b1;
                    o_mem_waddr        = r_best_idx;
                    n_res.victim_frame = VICTIM_W'(r_best_idx);
                end else begin
                    n_res.status = STATUS_EMPTY;
                end
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_idx   <= n_idx;
            r_rd_v  <= n_rd_v;
        end
    end

    // Payload and sweep bookkeeping
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_item     <= n_item;
        r_found    <= n_found;
        r_best_idx <= n_best_idx;
        r_best_age <= n_best_age;
        r_res      <= n_res;
    end

endmodule

FILE: src/aging_page_replacement.sv
// ============================================================================
// aging_page_replacement - aging (approximate LRU) frame table
// Top level: command/result channels, output register, sequencer and RAM.
// ============================================================================
// The table keeps, for every frame slot, a valid bit, a referenced mark, an
// 8-bit owner and an AGE_BITS aging counter in one synchronous RAM word. One
// command is worked at a time. Insert is a single write, access a read and
// then a write back through the single RAM port pair; aging tick and evict
// both sweep every slot through the RAM read port, one slot a cycle, with
// the write-back of the previous slot overlapped for a tick; evict then
// frees the chosen victim. After reset the block clears the table and holds
// ready low meanwhile. A finished result waits in an output register while
// the next item is taken.
module aging_page_replacement import apr_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int AGE_BITS   = AGE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    apr_cmd_if.sink      i_cmd,
    apr_res_if.source    o_res
);

    localparam int IDX_W  = $clog2(NUM_FRAMES);
    localparam int WORD_W = AGE_BITS + 10;

    t_cmd              cmd_item;
    logic              cmd_ready;
    logic              res_valid;
    logic              res_ready;
    t_res              res_item;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [WORD_W-1:0] mem_rdata;
    logic              r_out_valid;
    t_res              r_out;

    // Gather the command item
    assign cmd_item = '{command:    i_cmd.command,
                        frame_slot: i_cmd.frame_slot,
                        process_id: i_cmd.process_id,
                        start_age:  i_cmd.start_age};
    assign i_cmd.ready = cmd_ready;

    apr_sweep_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .AGE_BITS   (AGE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res_item),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    apr_frame_ram #(
        .DEPTH (NUM_FRAMES),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: load when empty or being drained
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res_item;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.victim_frame = r_out.victim_frame;

endmodule

FILE: src/apr_checker.sv
// ============================================================================
// apr_checker - port-level checks of the aging frame table
// Tracks items in flight and checks their bound, reset behaviour, the empty
// victim code and the result hand-off; attached to the top level by a bind.
// ============================================================================
module apr_checker import apr_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cmd_valid,
    input logic                i_cmd_ready,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input logic                i_res_status,
    input logic [VICTIM_W-1:0] i_res_victim
);

    logic [1:0] r_pending;
    logic       cmd_acc;
    logic       res_acc;

    assign cmd_acc = i_cmd_valid && i_cmd_ready;
    assign res_acc = i_res_valid && i_res_ready;

    // Count items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (cmd_acc && !res_acc) begin
            r_pending <= r_pending + 2'd1;
        end else if (res_acc && !cmd_acc) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    // No result without an item behind it
    a_res_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> r_pending != 2'd0)
        else $error("result shown with no item in flight");

    // At most two items in flight: one in the sequencer, one in the output register
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3 && !(r_pending == 2'd2 && cmd_acc))
        else $error("more items in flight than the block can hold");

    // Clearing pass holds ready low right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_cmd_ready)
        else $error("item accepted during the clearing pass");

    // Empty evict reports slot zero
    a_empty_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status == STATUS_EMPTY |-> i_res_victim == '0)
        else $error("empty status with a nonzero victim");

    // Result holds while stalled
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status)
                                        && $stable(i_res_victim))
        else $error("stalled result dropped or changed");

endmodule

bind aging_page_replacement apr_checker u_apr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_victim (o_res.victim_frame)
);
